// ===== rtl/core/clr_pkg.sv =====
package clr_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 800;
  localparam int FRAME_HEIGHT = 600;
  localparam int CELLS        = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(CELLS);
  localparam int COL_W        = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W        = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  localparam int COORD_W   = 12;
  localparam int ERR_W     = 16;
  localparam int COUNT_W   = 13;
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] BG_RED   = 8'd30;
  localparam logic [7:0] BG_GREEN = 8'd30;
  localparam logic [7:0] BG_BLUE  = 8'd35;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [23:0]               rgb_t;

  localparam rgb_t BG_RGB = {BG_RED, BG_GREEN, BG_BLUE};

  typedef enum logic {
    MODE_DRAW = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  // classified request, front to back
  typedef struct packed {
    mode_t  mode;
    coord_t c0;
    coord_t r0;
    coord_t c1;
    coord_t r1;
    rgb_t   rgb;
    err_t   span_c;     // |dc|, zero or positive
    err_t   span_r;     // -|dr|, negative or zero
    err_t   err0;
    logic   step_c_neg;
    logic   step_r_neg;
    logic   start_in;
    addr_t  start_addr;
  } cmd_t;

  function automatic logic in_frame(coord_t c, coord_t r);
    return !c[COORD_W-1] && !r[COORD_W-1] &&
           ({1'b0, c} < (COORD_W+1)'(FRAME_WIDTH)) &&
           ({1'b0, r} < (COORD_W+1)'(FRAME_HEIGHT));
  endfunction

  // row * width + col, only meaningful for in-frame points
  function automatic addr_t cell_addr(coord_t c, coord_t r);
    return ADDR_W'(r[ROW_W-1:0]) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(c[COL_W-1:0]);
  endfunction

endpackage

// ===== rtl/core/clipped_line_rasterizer.sv =====
// channel   | handshake        | payload
// ----------+------------------+---------------------------------------------
// request   | push / full      | mode, start_col, start_row, end_col, end_row,
//           |                  | red_in, green_in, blue_in
// result    | empty / pop      | red_out, green_out, blue_out, outside_frame,
//           |                  | pixels_written
//
// Walk: a draw walks one pixel per cycle from start to end point; a read registers the
//   address, then the frame store read, then the result; off the frame, from idle.
// Reset: rst is synchronous; the back end then writes the background 30,30,35 over
//   all 480000 cells of the frame store, one pixel a cycle; up to three requests queue.
// Stalls: push is taken while a line is walked until the queue fills; the back end
//   starts a request only with the result slot free, so a held result stalls it.
module clipped_line_rasterizer (
  input  logic           clk,
  input  logic           rst,
  // request side
  input  logic           push,
  output logic           full,
  input  logic           mode,
  input  clr_pkg::coord_t start_col,
  input  clr_pkg::coord_t start_row,
  input  clr_pkg::coord_t end_col,
  input  clr_pkg::coord_t end_row,
  input  logic [7:0]     red_in,
  input  logic [7:0]     green_in,
  input  logic [7:0]     blue_in,
  // result side
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     red_out,
  output logic [7:0]     green_out,
  output logic [7:0]     blue_out,
  output logic           outside_frame,
  output clr_pkg::count_t pixels_written
);
  import clr_pkg::*;

  cmd_t   f_cmd, q_cmd;
  logic   f_push, q_full, q_valid, q_pop;
  logic   res_valid;
  rgb_t   res_rgb;

  // front: register the request, work out spans, steps and start address
  clr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .start_col (start_col),
    .start_row (start_row),
    .end_col   (end_col),
    .end_row   (end_row),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .cmd_push  (f_push),
    .cmd       (f_cmd),
    .cmd_full  (q_full)
  );

  // short queue decoupling front and back
  clr_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_cmd),
    .valid (q_valid)
  );

  // back: frame store, clear sweep, line walker, reads, result slot
  clr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (q_cmd),
    .cmd_pop     (q_pop),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .res_rgb     (res_rgb),
    .res_outside (outside_frame),
    .res_count   (pixels_written)
  );

  assign empty     = !res_valid;
  assign red_out   = res_rgb[23:16];
  assign green_out = res_rgb[15:8];
  assign blue_out  = res_rgb[7:0];

endmodule

// ===== rtl/core/clr_front.sv =====
module clr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           mode,
  input  clr_pkg::coord_t start_col,
  input  clr_pkg::coord_t start_row,
  input  clr_pkg::coord_t end_col,
  input  clr_pkg::coord_t end_row,
  input  logic [7:0]     red_in,
  input  logic [7:0]     green_in,
  input  logic [7:0]     blue_in,
  output logic           cmd_push,
  output clr_pkg::cmd_t  cmd,
  input  logic           cmd_full
);
  import clr_pkg::*;

  logic                  valid;
  logic                  accept;
  logic signed [COORD_W:0] dc, dr, abs_c, abs_r;
  cmd_t                  cls;

  assign full     = valid && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = valid && !cmd_full;

  always_comb begin
    dc    = {end_col[COORD_W-1], end_col} - {start_col[COORD_W-1], start_col};
    dr    = {end_row[COORD_W-1], end_row} - {start_row[COORD_W-1], start_row};
    abs_c = dc[COORD_W] ? -dc : dc;
    abs_r = dr[COORD_W] ? -dr : dr;

    cls.mode       = mode_t'(mode);
    cls.c0         = start_col;
    cls.r0         = start_row;
    cls.c1         = end_col;
    cls.r1         = end_row;
    cls.rgb        = {red_in, green_in, blue_in};
    cls.span_c     = ERR_W'(abs_c);
    cls.span_r     = -ERR_W'(abs_r);
    cls.err0       = ERR_W'(abs_c) - ERR_W'(abs_r);
    cls.step_c_neg = !(start_col < end_col);
    cls.step_r_neg = !(start_row < end_row);
    cls.start_in   = in_frame(start_col, start_row);
    cls.start_addr = cell_addr(start_col, start_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept || (valid && cmd_full);
    end
    if (accept) begin
      cmd <= cls;
    end
  end

endmodule

// ===== rtl/core/clr_cmd_fifo.sv =====
module clr_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  clr_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output clr_pkg::cmd_t rdata,
  output logic          valid
);
  import clr_pkg::*;

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMD_CNT_W-1:0] cnt;
  logic                 do_push, do_pop;

  assign full    = (cnt == CMD_CNT_W'(CMD_DEPTH));
  assign valid   = (cnt != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
    end
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue count out of range");

endmodule

// ===== rtl/core/clr_back.sv =====
module clr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  clr_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  input  logic           res_pop,
  output clr_pkg::rgb_t  res_rgb,
  output logic           res_outside,
  output clr_pkg::count_t res_count
);
  import clr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_RDONE
  } state_t;

  state_t state;

  // frame store
  rgb_t  mem [CELLS];
  rgb_t  rd_data;
  addr_t rd_addr;
  addr_t clr_addr;
  logic  mem_we;
  addr_t mem_waddr;
  rgb_t  mem_wdata;

  // walker
  coord_t col, row, c1, r1;
  err_t   err, span_c, span_r;
  logic   step_c_neg, step_r_neg;
  rgb_t   rgb;
  count_t count;

  logic signed [ERR_W:0] twice;
  logic   move_c, move_r, at_end, cur_in;
  count_t count_plus;
  err_t   err_next;

  // pixel write stage
  logic   wp_valid;
  coord_t wp_col, wp_row;
  rgb_t   wp_rgb;

  assign cmd_pop = (state == ST_IDLE) && cmd_valid && !res_valid;

  always_comb begin
    twice      = {err, 1'b0};
    move_c     = twice >= (ERR_W+1)'(span_r);
    move_r     = twice <= (ERR_W+1)'(span_c);
    err_next   = err + (move_c ? span_r : '0) + (move_r ? span_c : '0);
    at_end     = (col == c1) && (row == r1);
    cur_in     = in_frame(col, row);
    count_plus = count + COUNT_W'(cur_in);
  end

  always_comb begin
    mem_we    = (state == ST_CLEAR) || wp_valid;
    mem_waddr = (state == ST_CLEAR) ? clr_addr : cell_addr(wp_col, wp_row);
    mem_wdata = (state == ST_CLEAR) ? BG_RGB : wp_rgb;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      wp_valid  <= 1'b0;
    end else begin
      wp_valid <= (state == ST_WALK) && cur_in;
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd.mode == MODE_READ) begin
              if (cmd.start_in) begin
                rd_addr <= cmd.start_addr;
                state   <= ST_READ;
              end else begin
                res_valid   <= 1'b1;
                res_rgb     <= '0;
                res_outside <= 1'b1;
                res_count   <= '0;
              end
            end else begin
              col        <= cmd.c0;
              row        <= cmd.r0;
              c1         <= cmd.c1;
              r1         <= cmd.r1;
              err        <= cmd.err0;
              span_c     <= cmd.span_c;
              span_r     <= cmd.span_r;
              step_c_neg <= cmd.step_c_neg;
              step_r_neg <= cmd.step_r_neg;
              rgb        <= cmd.rgb;
              count      <= '0;
              state      <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          wp_col   <= col;
          wp_row   <= row;
          wp_rgb   <= rgb;
          if (at_end) begin
            res_valid   <= 1'b1;
            res_rgb     <= '0;
            res_outside <= 1'b0;
            res_count   <= count_plus;
            state       <= ST_IDLE;
          end else begin
            count <= count_plus;
            err   <= err_next;
            if (move_c) begin
              col <= step_c_neg ? col - 1'b1 : col + 1'b1;
            end
            if (move_r) begin
              row <= step_r_neg ? row - 1'b1 : row + 1'b1;
            end
          end
        end
        ST_READ: begin
          state <= ST_RDONE;
        end
        ST_RDONE: begin
          res_valid   <= 1'b1;
          res_rgb     <= rd_data;
          res_outside <= 1'b0;
          res_count   <= '0;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!cmd_pop && !res_valid && !wp_valid))
    else $error("request taken during frame clear");

  a_walk_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !res_valid)
    else $error("walk running while a result is pending");

  a_write_in_frame: assert property (@(posedge clk) disable iff (rst)
    wp_valid |-> in_frame(wp_col, wp_row))
    else $error("pixel write outside the frame");

endmodule
